>>> src/ntid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntid_pkg: shared types and constants for the name-to-id lookup table
// Request and status codes, per-cell control word and parameter defaults.
// ----------------------------------------------------------------------------
package ntid_pkg;

  // Parameter defaults
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int NAME_BYTES_DEF    = 8;

  // Fixed field widths
  localparam int ID_W    = 8;
  localparam int NAME_W  = 64;
  localparam int BYTES_W = 4;

  // Shortest message that carries a name
  localparam logic [BYTES_W-1:0] MIN_MSG_BYTES = 4'd3;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_LOOKUP   = 2'd1,
    REQ_STOP     = 2'd2,
    REQ_UNKNOWN  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RECV_FAIL = 3'd1,
    ST_SHORT     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;    // compare stored name against the incoming word
    logic shift_en;  // take the neighbor's entry (append at the head)
    logic upd_en;    // overwrite the id of the matching entry
  } cell_ctrl_t;

endpackage : ntid_pkg
`default_nettype wire

>>> src/ntid_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntid_cell: one entry of the lookup chain
// Holds a name and an id, flags a match against the incoming name and shifts
// its entry to the next cell when a new name is appended at the head.
// ----------------------------------------------------------------------------
module ntid_cell
  import ntid_pkg::*;
#(
  parameter int KEY_W = NAME_BYTES_DEF * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic             live,
  input  wire logic [KEY_W-1:0] cmp_key,
  input  wire logic [ID_W-1:0]  new_id,
  input  wire logic [KEY_W-1:0] prev_key,
  input  wire logic [ID_W-1:0]  prev_id,
  output logic [KEY_W-1:0]      key_r,
  output logic [ID_W-1:0]       id_r,
  output logic                  hit_r
);

  logic hit_nxt;

  // Match only entries that lie below the fill count
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.cmp_en) begin
      hit_nxt = live && (key_r == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  // Shift the neighbor's entry in, or update the id in place on a hit
  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      key_r <= prev_key;
      id_r  <= prev_id;
    end else if (ctrl.upd_en && hit_r) begin
      id_r  <= new_id;
    end
  end

endmodule : ntid_cell
`default_nettype wire

>>> src/name_to_id_register_lookup_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// name_to_id_register_lookup_table: associative name-to-id table
// Register, lookup and stop requests against a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: type, packed
//   name, sender id, message length and a receive-failed flag. The result
//   channel (out_valid/out_ready) returns at most one reply word per request.
//   A request is latched while every cell compares its stored name; the
//   resolve state gathers the single matching cell and commits the write. No
//   new request is taken before the last resolves; the reply stays in an
//   output register, so the next request is accepted while a reply waits. A
//   register of a new name pushes it in at the head of the cell chain and
//   every older entry moves one cell down; a known name has its id updated,
//   but a full table rejects every register. A stop that is neither failed
//   nor short, and every request after it, produce no reply; requests are
//   still accepted and dropped. A request needing a reply waits in resolve
//   while a reply is stalled. Reset empties the table and clears the halt.
// ----------------------------------------------------------------------------
module name_to_id_register_lookup_table
  import ntid_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [NAME_W-1:0]  in_name_key,
  input  wire logic [ID_W-1:0]    in_sender_id,
  input  wire logic [BYTES_W-1:0] in_msg_bytes,
  input  wire logic               in_receive_failed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ID_W-1:0]         out_reply_to,
  output logic [2:0]              out_status,
  output logic [ID_W-1:0]         out_found_id
);

  localparam int KEY_W = NAME_BYTES * 8;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  state_t               state_r, state_nxt;
  logic                 halted_r, halted_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  req_t                 req_r;
  logic [KEY_W-1:0]     key_r;
  logic [ID_W-1:0]      sender_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic                 failed_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      reply_to_r, reply_to_nxt;
  status_t              status_r, status_nxt;
  logic [ID_W-1:0]      found_r, found_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 table_full;
  logic                 any_hit;
  logic [ID_W-1:0]      hit_id;
  logic                 do_append;
  logic                 do_update;
  cell_ctrl_t           ctrl;

  logic [KEY_W-1:0]     cell_key [TABLE_ENTRIES];
  logic [ID_W-1:0]      cell_id  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_hit;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign table_full = (count_r == CNT_W'(TABLE_ENTRIES));

  assign ctrl.cmp_en   = in_fire;
  assign ctrl.shift_en = do_append;
  assign ctrl.upd_en   = do_update;

  // Chain of entry cells; the head takes the pending request's name
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic [ID_W-1:0]  prev_id;
    if (i == 0) begin : g_head
      assign prev_key = key_r;
      assign prev_id  = sender_r;
    end else begin : g_link
      assign prev_key = cell_key[i-1];
      assign prev_id  = cell_id[i-1];
    end
    ntid_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .live     (count_r > CNT_W'(i)),
      .cmp_key  (in_name_key[KEY_W-1:0]),
      .new_id   (sender_r),
      .prev_key (prev_key),
      .prev_id  (prev_id),
      .key_r    (cell_key[i]),
      .id_r     (cell_id[i]),
      .hit_r    (cell_hit[i])
    );
  end

  // Gather the id of the single matching cell
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_id = hit_id | (cell_hit[i] ? cell_id[i] : '0);
    end
  end
  assign any_hit = |cell_hit;

  // Decide the reply and the table write for the latched request
  always_comb begin
    state_nxt     = state_r;
    halted_nxt    = halted_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    reply_to_nxt  = reply_to_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    do_append     = 1'b0;
    do_update     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && !halted_r) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!failed_r && !(bytes_r < MIN_MSG_BYTES) && req_r == REQ_STOP) begin
          halted_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          reply_to_nxt  = sender_r;
          status_nxt    = ST_OK;
          found_nxt     = '0;
          if (failed_r) begin
            status_nxt = ST_RECV_FAIL;
          end else if (bytes_r < MIN_MSG_BYTES) begin
            status_nxt = ST_SHORT;
          end else begin
            case (req_r)
              REQ_REGISTER: begin
                if (table_full) begin
                  status_nxt = ST_FULL;
                end else if (any_hit) begin
                  do_update = 1'b1;
                end else begin
                  do_append = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              REQ_LOOKUP: begin
                if (any_hit) begin
                  found_nxt = hit_id;
                end else begin
                  status_nxt = ST_NOT_FOUND;
                end
              end
              default: begin
                status_nxt = ST_UNKNOWN;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, table fill and the reply register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halted_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    reply_to_r <= reply_to_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    if (in_fire) begin
      req_r    <= req_t'(in_req_type);
      key_r    <= in_name_key[KEY_W-1:0];
      sender_r <= in_sender_id;
      bytes_r  <= in_msg_bytes;
      failed_r <= in_receive_failed;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_reply_to = reply_to_r;
  assign out_status   = status_r;
  assign out_found_id = found_r;

`ifndef SYNTH
  // Names in the table are unique, so at most one cell matches
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE) |-> $onehot0(cell_hit))
    else $error("more than one cell matches the name");

  // Fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  // The table grows by at most one entry per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count jumped");

  // A halted block produces no new reply
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !out_valid_r) |=> !out_valid_r)
    else $error("reply after stop");

  // A request resolves as soon as the reply register is free
  a_resolve_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && out_free) |=> (state_r == S_IDLE))
    else $error("request did not resolve");
`endif

endmodule : name_to_id_register_lookup_table
`default_nettype wire
